@@ src/voxel_face_culling_mesher_top_defines.svh @@
`ifndef VOXEL_FACE_CULLING_MESHER_TOP_DEFINES_SVH
`define VOXEL_FACE_CULLING_MESHER_TOP_DEFINES_SVH

// Checks that hold in the same cycle, sampled on the rising clock outside reset.
`define VFCM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("voxel mesher port check failed");

// Checks whose consequence is due in the next cycle.
`define VFCM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("voxel mesher port check failed");

`endif

@@ src/vfcm_pkg.sv @@
package vfcm_pkg;

    localparam int MAX_EXTENT_X = 16;
    localparam int MAX_EXTENT_Y = 16;
    localparam int MAX_EXTENT_Z = 16;
    localparam int STORE_DEPTH  = MAX_EXTENT_X * MAX_EXTENT_Y * MAX_EXTENT_Z;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);

    localparam int COORD_W   = 4;
    localparam int SIZE_W    = 5;
    localparam int BRIGHT_W  = 16;
    localparam int WORD_W    = 32;
    localparam int CHAN_W    = 8;
    localparam int CMP_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam int OPCODE_W  = 2;

    localparam int NUM_FACES = 6;
    localparam int FACE_W    = 3;
    localparam int SHADE_W   = 9;
    localparam int PROD1_W   = CHAN_W + SHADE_W;
    localparam int PROD2_W   = PROD1_W + BRIGHT_W;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hff;

    localparam logic [FACE_W-1:0] FACE_TOP    = 3'd0;
    localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd1;
    localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd2;
    localparam logic [FACE_W-1:0] FACE_BACK   = 3'd3;
    localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd4;
    localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd5;

    // Read slots of a mesh item: the cell itself, then one per face in face order.
    localparam int RD_IDX_W = 3;
    localparam logic [RD_IDX_W-1:0] RD_CENTER = 3'd0;
    localparam logic [RD_IDX_W-1:0] RD_TOP    = 3'd1;
    localparam logic [RD_IDX_W-1:0] RD_FRONT  = 3'd2;
    localparam logic [RD_IDX_W-1:0] RD_LEFT   = 3'd3;
    localparam logic [RD_IDX_W-1:0] RD_BACK   = 3'd4;
    localparam logic [RD_IDX_W-1:0] RD_RIGHT  = 3'd5;
    localparam logic [RD_IDX_W-1:0] RD_BOTTOM = 3'd6;

    localparam int CQ_DEPTH = 2;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 3);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_X,
        CFG_SIZE_Y,
        CFG_SIZE_Z,
        CFG_BRIGHTNESS
    } t_cfg_reg;

    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE,
        OP_MESH_OPAQUE,
        OP_MESH_TRANSP,
        OP_UNUSED
    } t_opcode;

    typedef enum logic {
        CMD_WRITE,
        CMD_MESH
    } t_cmd_kind;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_READ,
        BK_WAIT,
        BK_EMIT
    } t_back_state;

    typedef struct packed {
        t_cmd_kind                kind;
        logic                     opaque;
        logic [COORD_W-1:0]       x;
        logic [COORD_W-1:0]       y;
        logic [COORD_W-1:0]       z;
        logic [WORD_W-1:0]        word;
        logic [NUM_FACES-1:0]     force_vis;
        logic [NUM_FACES-1:0]     allow_vis;
    } t_cmd;

    typedef struct packed {
        logic [FACE_W-1:0]  face;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [CHAN_W-1:0]  alpha;
        logic               last;
    } t_face_meta;

    typedef struct packed {
        t_face_meta         meta;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
    } t_result;

    // Store address {z,x,y}.
    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y,
        input logic [COORD_W-1:0] z
    );
        logic [31:0] a;
        a = (32'(z) * 32'(MAX_EXTENT_X) + 32'(x)) * 32'(MAX_EXTENT_Y) + 32'(y);
        return a[ADDR_W-1:0];
    endfunction

    function automatic logic [SHADE_W-1:0] face_shade(input logic [FACE_W-1:0] f);
        logic [SHADE_W-1:0] s;
        case (f)
            FACE_TOP:                s = 9'd256;
            FACE_FRONT, FACE_BACK:   s = 9'd205;
            FACE_LEFT, FACE_RIGHT:   s = 9'd154;
            FACE_BOTTOM:             s = 9'd128;
            default:                 s = 9'd0;
        endcase
        return s;
    endfunction

endpackage

@@ src/voxel_face_culling_mesher_top.sv @@
// Write item: stored in the same cycle that it leaves the command queue, no result.
// Mesh item: pop, 7 reads of the single read port, decide; then the visible faces
// go out one per cycle while the output queue has a free slot for each.
// The back end takes the next item from the command queue only once it is idle again.
// Reset is synchronous, active low; afterwards the store is cleared one word a cycle,
// all 4096 words, with full held high. Configuration writes are taken during the clear.
module voxel_face_culling_mesher_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [vfcm_pkg::OPCODE_W-1:0]     i_opcode,
    input  logic [vfcm_pkg::COORD_W-1:0]      i_cell_x,
    input  logic [vfcm_pkg::COORD_W-1:0]      i_cell_y,
    input  logic [vfcm_pkg::COORD_W-1:0]      i_cell_z,
    input  logic [vfcm_pkg::WORD_W-1:0]       i_cell_word,
    output logic                              empty,
    input  logic                              pop,
    output logic [vfcm_pkg::FACE_W-1:0]       o_face,
    output logic [vfcm_pkg::COORD_W-1:0]      o_base_x,
    output logic [vfcm_pkg::COORD_W-1:0]      o_base_y,
    output logic [vfcm_pkg::COORD_W-1:0]      o_base_z,
    output logic [vfcm_pkg::CHAN_W-1:0]       o_red_out,
    output logic [vfcm_pkg::CHAN_W-1:0]       o_green_out,
    output logic [vfcm_pkg::CHAN_W-1:0]       o_blue_out,
    output logic [vfcm_pkg::CHAN_W-1:0]       o_alpha_out,
    output logic                              o_last_face,
    input  logic                              i_cfg_we,
    input  logic [vfcm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [vfcm_pkg::BRIGHT_W-1:0]     i_cfg_wdata
);
    import vfcm_pkg::*;

    logic                q_push;
    t_cmd                q_in_cmd;
    logic                q_full;
    logic                q_pop;
    t_cmd                q_out_cmd;
    logic                q_empty;
    logic                clearing;
    logic [BRIGHT_W-1:0] brightness;
    t_result             result;

    vfcm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_opcode     (i_opcode),
        .i_cell_x     (i_cell_x),
        .i_cell_y     (i_cell_y),
        .i_cell_z     (i_cell_z),
        .i_cell_word  (i_cell_word),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_clearing   (clearing),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_cmd      (q_in_cmd),
        .o_brightness (brightness)
    );

    vfcm_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_out_cmd),
        .o_empty (q_empty)
    );

    vfcm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_cmd      (q_out_cmd),
        .o_q_pop      (q_pop),
        .i_brightness (brightness),
        .o_clearing   (clearing),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_result     (result)
    );

    assign o_face      = result.meta.face;
    assign o_base_x    = result.meta.x;
    assign o_base_y    = result.meta.y;
    assign o_base_z    = result.meta.z;
    assign o_alpha_out = result.meta.alpha;
    assign o_last_face = result.meta.last;
    assign o_red_out   = result.red;
    assign o_green_out = result.green;
    assign o_blue_out  = result.blue;

endmodule

@@ src/vfcm_front.sv @@
module vfcm_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    output logic                               o_full,
    input  logic [vfcm_pkg::OPCODE_W-1:0]      i_opcode,
    input  logic [vfcm_pkg::COORD_W-1:0]       i_cell_x,
    input  logic [vfcm_pkg::COORD_W-1:0]       i_cell_y,
    input  logic [vfcm_pkg::COORD_W-1:0]       i_cell_z,
    input  logic [vfcm_pkg::WORD_W-1:0]        i_cell_word,
    input  logic                               i_cfg_we,
    input  logic [vfcm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [vfcm_pkg::BRIGHT_W-1:0]      i_cfg_wdata,
    input  logic                               i_clearing,
    input  logic                               i_q_full,
    output logic                               o_q_push,
    output vfcm_pkg::t_cmd                     o_q_cmd,
    output logic [vfcm_pkg::BRIGHT_W-1:0]      o_brightness
);
    import vfcm_pkg::*;

    logic [SIZE_W-1:0]   r_size_x;
    logic [SIZE_W-1:0]   r_size_y;
    logic [SIZE_W-1:0]   r_size_z;
    logic [BRIGHT_W-1:0] r_brightness;

    logic [CMP_W-1:0] wx, wy, wz;
    logic [CMP_W-1:0] cx, cy, cz;
    logic             in_store;
    logic             in_world;
    logic             keep;
    t_opcode          op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x     <= SIZE_W'(16);
            r_size_y     <= SIZE_W'(16);
            r_size_z     <= SIZE_W'(16);
            r_brightness <= BRIGHT_W'(256);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_SIZE_X:     r_size_x     <= i_cfg_wdata[SIZE_W-1:0];
                CFG_SIZE_Y:     r_size_y     <= i_cfg_wdata[SIZE_W-1:0];
                CFG_SIZE_Z:     r_size_z     <= i_cfg_wdata[SIZE_W-1:0];
                CFG_BRIGHTNESS: r_brightness <= i_cfg_wdata;
            endcase
        end
    end

    // Sizes beyond the store extent act as the extent itself.
    assign wx = (CMP_W'(r_size_x) > CMP_W'(MAX_EXTENT_X)) ? CMP_W'(MAX_EXTENT_X)
                                                          : CMP_W'(r_size_x);
    assign wy = (CMP_W'(r_size_y) > CMP_W'(MAX_EXTENT_Y)) ? CMP_W'(MAX_EXTENT_Y)
                                                          : CMP_W'(r_size_y);
    assign wz = (CMP_W'(r_size_z) > CMP_W'(MAX_EXTENT_Z)) ? CMP_W'(MAX_EXTENT_Z)
                                                          : CMP_W'(r_size_z);

    assign cx = CMP_W'(i_cell_x);
    assign cy = CMP_W'(i_cell_y);
    assign cz = CMP_W'(i_cell_z);

    assign in_store = (cx < CMP_W'(MAX_EXTENT_X)) && (cy < CMP_W'(MAX_EXTENT_Y))
                   && (cz < CMP_W'(MAX_EXTENT_Z));
    assign in_world = (cx < wx) && (cy < wy) && (cz < wz);

    assign op           = t_opcode'(i_opcode);
    assign o_full       = i_q_full || i_clearing;
    assign o_q_push     = i_push && !o_full && keep;
    assign o_brightness = r_brightness;

    always_comb begin
        o_q_cmd           = '0;
        o_q_cmd.x         = i_cell_x;
        o_q_cmd.y         = i_cell_y;
        o_q_cmd.z         = i_cell_z;
        o_q_cmd.word      = i_cell_word;
        o_q_cmd.kind      = CMD_MESH;
        keep              = 1'b0;
        unique case (op)
            OP_WRITE: begin
                o_q_cmd.kind = CMD_WRITE;
                keep         = in_store;
            end
            OP_MESH_OPAQUE: begin
                o_q_cmd.opaque = 1'b1;
                keep           = in_world;
            end
            OP_MESH_TRANSP: begin
                keep = in_world;
            end
            OP_UNUSED: begin
                keep = 1'b0;
            end
        endcase

        // Edge rules: top and bottom always show at the world edge, sides never do.
        o_q_cmd.force_vis[FACE_TOP]    = (cy + CMP_W'(1)) >= wy;
        o_q_cmd.force_vis[FACE_BOTTOM] = (cy == '0);
        o_q_cmd.allow_vis[FACE_TOP]    = 1'b1;
        o_q_cmd.allow_vis[FACE_FRONT]  = (cz != '0);
        o_q_cmd.allow_vis[FACE_LEFT]   = (cx != '0);
        o_q_cmd.allow_vis[FACE_BACK]   = (cz + CMP_W'(1)) < wz;
        o_q_cmd.allow_vis[FACE_RIGHT]  = (cx + CMP_W'(1)) < wx;
        o_q_cmd.allow_vis[FACE_BOTTOM] = 1'b1;
    end

endmodule

@@ src/vfcm_cmd_queue.sv @@
module vfcm_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  vfcm_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output vfcm_pkg::t_cmd o_cmd,
    output logic           o_empty
);
    import vfcm_pkg::*;

    t_cmd                r_mem [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] r_wr_ptr;
    logic [CQ_PTR_W-1:0] r_rd_ptr;
    logic [CQ_CNT_W-1:0] r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == CQ_CNT_W'(CQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CQ_CNT_W'(do_push) - CQ_CNT_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

@@ src/vfcm_back.sv @@
module vfcm_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_empty,
    input  vfcm_pkg::t_cmd                 i_q_cmd,
    output logic                           o_q_pop,
    input  logic [vfcm_pkg::BRIGHT_W-1:0]  i_brightness,
    output logic                           o_clearing,
    output logic                           o_empty,
    input  logic                           i_pop,
    output vfcm_pkg::t_result              o_result
);
    import vfcm_pkg::*;

    t_back_state r_state, n_state;

    logic [WORD_W-1:0]    r_store [STORE_DEPTH];
    logic [WORD_W-1:0]    r_rdata;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [WORD_W-1:0]    mem_wdata;
    logic [ADDR_W-1:0]    mem_raddr;

    logic [ADDR_W-1:0]    r_clr_addr, n_clr_addr;
    t_cmd                 r_cmd;
    logic                 load_cmd;
    logic [RD_IDX_W-1:0]  r_rd_idx, n_rd_idx;
    logic                 rd_issue;
    logic                 r_rd_v;
    logic [RD_IDX_W-1:0]  r_rd_tag;
    logic [RD_IDX_W-1:0]  fidx;
    logic [COORD_W-1:0]   nx, ny, nz;

    logic [WORD_W-1:0]    r_cell, n_cell;
    logic [NUM_FACES-1:0] r_vis, n_vis;
    logic                 cell_pass;

    logic [FACE_W-1:0]    sel_face;
    logic [NUM_FACES-1:0] sel_hot;
    logic [NUM_FACES-1:0] vis_rest;
    logic                 emit;
    logic                 credit_ok;
    logic [SHADE_W-1:0]   sel_shade;

    logic                 r_s1_v;
    t_face_meta           r_s1_meta;
    logic [PROD1_W-1:0]   r_s1_r, r_s1_g, r_s1_b;
    logic                 r_s2_v;
    t_face_meta           r_s2_meta;
    logic [PROD2_W-1:0]   r_s2_r, r_s2_g, r_s2_b;

    t_result              r_oq [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]  r_oq_wr_ptr;
    logic [OQ_PTR_W-1:0]  r_oq_rd_ptr;
    logic [OQ_CNT_W-1:0]  r_oq_count;
    logic                 oq_pop;
    t_result              oq_entry;

    function automatic logic [CHAN_W-1:0] round_sat(input logic [PROD2_W-1:0] p);
        logic [PROD2_W:0] s;
        s = {1'b0, p} + (PROD2_W + 1)'(32768);
        return (s[PROD2_W:16] > (PROD2_W - 15)'(255)) ? CHAN_W'(255) : s[23:16];
    endfunction

    // Store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_store[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_CLEAR;
            r_clr_addr <= '0;
            r_rd_idx   <= '0;
            r_rd_v     <= 1'b0;
            r_rd_tag   <= RD_CENTER;
            r_vis      <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_rd_idx   <= n_rd_idx;
            r_rd_v     <= rd_issue;
            r_rd_tag   <= r_rd_idx;
            r_vis      <= n_vis;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
        if (load_cmd) begin
            r_cmd <= i_q_cmd;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_rd_idx   = r_rd_idx;
        o_q_pop    = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_clr_addr;
        mem_wdata  = '0;
        rd_issue   = 1'b0;
        load_cmd   = 1'b0;
        emit       = 1'b0;
        unique case (r_state)
            BK_CLEAR: begin
                mem_we     = 1'b1;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    if (i_q_cmd.kind == CMD_WRITE) begin
                        mem_we    = 1'b1;
                        mem_waddr = cell_addr(i_q_cmd.x, i_q_cmd.y, i_q_cmd.z);
                        mem_wdata = i_q_cmd.word;
                    end else begin
                        load_cmd = 1'b1;
                        n_rd_idx = RD_CENTER;
                        n_state  = BK_READ;
                    end
                end
            end
            BK_READ: begin
                rd_issue = 1'b1;
                n_rd_idx = r_rd_idx + 1'b1;
                if (r_rd_idx == RD_BOTTOM) begin
                    n_state = BK_WAIT;
                end
            end
            BK_WAIT: begin
                // The bottom neighbor lands in this cycle, so decide on the merged mask.
                n_state = (cell_pass && (n_vis != '0)) ? BK_EMIT : BK_IDLE;
            end
            BK_EMIT: begin
                if (credit_ok) begin
                    emit = 1'b1;
                    if (vis_rest == '0) begin
                        n_state = BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        nx = r_cmd.x;
        ny = r_cmd.y;
        nz = r_cmd.z;
        case (r_rd_idx)
            RD_TOP:    ny = r_cmd.y + COORD_W'(1);
            RD_FRONT:  nz = r_cmd.z - COORD_W'(1);
            RD_LEFT:   nx = r_cmd.x - COORD_W'(1);
            RD_BACK:   nz = r_cmd.z + COORD_W'(1);
            RD_RIGHT:  nx = r_cmd.x + COORD_W'(1);
            RD_BOTTOM: ny = r_cmd.y - COORD_W'(1);
            default: begin
                nx = r_cmd.x;
            end
        endcase
        mem_raddr = cell_addr(nx, ny, nz);
    end

    assign cell_pass = (r_cell != '0)
                    && (r_cmd.opaque ? (r_cell[CHAN_W-1:0] == ALPHA_OPAQUE)
                                     : (r_cell[CHAN_W-1:0] != ALPHA_OPAQUE));

    assign fidx = r_rd_tag - RD_TOP;

    always_comb begin
        logic found;
        found    = 1'b0;
        sel_face = FACE_TOP;
        sel_hot  = '0;
        for (int f = 0; f < NUM_FACES; f++) begin
            if (r_vis[f] && !found) begin
                found      = 1'b1;
                sel_face   = FACE_W'(f);
                sel_hot[f] = 1'b1;
            end
        end
    end

    assign vis_rest  = r_vis & ~sel_hot;
    assign sel_shade = face_shade(sel_face);

    // A face may enter the shading pipe only if its queue slot is already free.
    assign credit_ok = (r_oq_count + OQ_CNT_W'(r_s1_v) + OQ_CNT_W'(r_s2_v))
                     < OQ_CNT_W'(OQ_DEPTH);

    always_comb begin
        n_cell = r_cell;
        n_vis  = r_vis;
        if (r_rd_v) begin
            if (r_rd_tag == RD_CENTER) begin
                n_cell = r_rdata;
                n_vis  = '0;
            end else begin
                n_vis[fidx] = r_cmd.force_vis[fidx]
                           || (r_cmd.allow_vis[fidx]
                               && (r_rdata[CHAN_W-1:0] != r_cell[CHAN_W-1:0]));
            end
        end
        if (emit) begin
            n_vis = vis_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= emit;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_s1_meta.face  <= sel_face;
            r_s1_meta.x     <= r_cmd.x;
            r_s1_meta.y     <= r_cmd.y;
            r_s1_meta.z     <= r_cmd.z;
            r_s1_meta.alpha <= r_cell[CHAN_W-1:0];
            r_s1_meta.last  <= (vis_rest == '0);
            r_s1_r <= PROD1_W'(r_cell[31:24]) * PROD1_W'(sel_shade);
            r_s1_g <= PROD1_W'(r_cell[23:16]) * PROD1_W'(sel_shade);
            r_s1_b <= PROD1_W'(r_cell[15:8])  * PROD1_W'(sel_shade);
        end
        r_s2_meta <= r_s1_meta;
        r_s2_r    <= PROD2_W'(r_s1_r) * PROD2_W'(i_brightness);
        r_s2_g    <= PROD2_W'(r_s1_g) * PROD2_W'(i_brightness);
        r_s2_b    <= PROD2_W'(r_s1_b) * PROD2_W'(i_brightness);
    end

    always_comb begin
        oq_entry.meta  = r_s2_meta;
        oq_entry.red   = round_sat(r_s2_r);
        oq_entry.green = round_sat(r_s2_g);
        oq_entry.blue  = round_sat(r_s2_b);
    end

    assign o_empty    = (r_oq_count == '0);
    assign oq_pop     = i_pop && !o_empty;
    assign o_result   = r_oq[r_oq_rd_ptr];
    assign o_clearing = (r_state == BK_CLEAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr_ptr <= '0;
            r_oq_rd_ptr <= '0;
            r_oq_count  <= '0;
        end else begin
            if (r_s2_v) begin
                r_oq_wr_ptr <= (r_oq_wr_ptr == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0
                                                                        : r_oq_wr_ptr + 1'b1;
            end
            if (oq_pop) begin
                r_oq_rd_ptr <= (r_oq_rd_ptr == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0
                                                                        : r_oq_rd_ptr + 1'b1;
            end
            r_oq_count <= r_oq_count + OQ_CNT_W'(r_s2_v) - OQ_CNT_W'(oq_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_v) begin
            r_oq[r_oq_wr_ptr] <= oq_entry;
        end
    end

endmodule

@@ src/vfcm_checker.sv @@
`include "voxel_face_culling_mesher_top_defines.svh"

module vfcm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          push,
    input logic                          full,
    input logic                          empty,
    input logic                          pop,
    input logic [vfcm_pkg::FACE_W-1:0]   o_face,
    input logic [vfcm_pkg::COORD_W-1:0]  o_base_x,
    input logic [vfcm_pkg::COORD_W-1:0]  o_base_y,
    input logic [vfcm_pkg::COORD_W-1:0]  o_base_z,
    input logic [vfcm_pkg::CHAN_W-1:0]   o_red_out,
    input logic [vfcm_pkg::CHAN_W-1:0]   o_green_out,
    input logic [vfcm_pkg::CHAN_W-1:0]   o_blue_out,
    input logic [vfcm_pkg::CHAN_W-1:0]   o_alpha_out,
    input logic                          o_last_face
);
    import vfcm_pkg::*;

    // Right after reset the store is being cleared and no word can be waiting.
    `VFCM_ASSERT_NOW(a_clear_after_reset, $past(!i_rst_n), full && empty)

    // Full is still held high in the cycle after that, while the clear pass goes on.
    `VFCM_ASSERT_NEXT(a_clear_holds_full, $past(!i_rst_n), full && !push || full)

    // Only the six face codes ever leave the block.
    `VFCM_ASSERT_NOW(a_face_code, !empty, (o_face <= FACE_BOTTOM))

    // A waiting word stays put until it is popped.
    `VFCM_ASSERT_NEXT(a_word_holds, !empty && !pop, !empty && $stable(o_face) && $stable(o_base_x) && $stable(o_base_y) && $stable(o_base_z) && $stable(o_red_out) && $stable(o_green_out) && $stable(o_blue_out) && $stable(o_alpha_out) && $stable(o_last_face))

endmodule

bind voxel_face_culling_mesher_top vfcm_checker u_vfcm_checker (.*);
